// ----- src/sbs_pkg.sv -----
package sbs_pkg;
   localparam int MAX_FRAMES = 65536;
   localparam int MAX_RADIUS = 1024;

   localparam logic [2:0] CSR_SNAP_KIND = 3'd0;
   localparam logic [2:0] CSR_DIRECTION = 3'd1;
   localparam logic [2:0] CSR_CHANNEL   = 3'd2;
   localparam logic [2:0] CSR_STEREO    = 3'd3;
   localparam logic [2:0] CSR_RADIUS    = 3'd4;
   localparam logic [2:0] CSR_STEP      = 3'd5;
   localparam logic [2:0] CSR_ORIGIN    = 3'd6;
   localparam logic [2:0] CSR_FRAMES    = 3'd7;

   localparam logic [1:0] DIR_NEAREST = 2'd0;
   localparam logic [1:0] DIR_BEFORE  = 2'd1;
   localparam logic [1:0] DIR_AFTER   = 2'd2;

   localparam logic [1:0] CH_BOTH  = 2'd0;
   localparam logic [1:0] CH_LEFT  = 2'd1;
   localparam logic [1:0] CH_RIGHT = 2'd2;

   localparam int POS_BITS = 17;

   typedef struct packed {
      logic       snap_kind;
      logic [1:0] direction;
      logic [1:0] channel_select;
      logic       stereo;
      logic [10:0] search_radius;
      logic [16:0] grid_step;
      logic [16:0] grid_origin;
      logic [16:0] frame_count;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{snap_kind: 1'b0, direction: DIR_NEAREST,
      channel_select: CH_BOTH, stereo: 1'b0, search_radius: 11'd0, grid_step: 17'd1,
      grid_origin: 17'd0, frame_count: 17'd0};
endpackage

// ----- src/sbs_ram.sv -----
module sbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- src/sample_boundary_snap.sv -----
// Sample buffer loader and boundary snapper. A load (mode 0) writes one frame into
// the left and right sample memories; it gives no result. A snap (mode 1) gives
// one result. Grid mode reduces (position - origin) modulo the step with a
// restoring shift-subtract unit, one bit a cycle. Zero-crossing mode checks one
// candidate boundary at a time, reading frames i-1 and i through the registered
// memory read port in the states S_CAND, S_RD1, S_RD2 and S_EVAL, two candidates
// per distance out to the search radius. Invalid settings answer with an error
// status. The block takes no new item while one is at work; a finished result
// waits in its own output register so the next item can start, and the sequencer
// holds in its last state only when a new result meets an older one still
// waiting.
module sample_boundary_snap
   import sbs_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [16:0]            req_position,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [16:0]            rsp_original_position,
   output logic [16:0]            rsp_snapped_position,
   output logic                   rsp_matched,
   output logic                   rsp_status,
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [16:0]            csr_data
);
   localparam int ABITS = $clog2(MAX_FRAMES);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_GRID  = 4'd3;
   localparam logic [3:0] S_CAND  = 4'd4;
   localparam logic [3:0] S_RD1   = 4'd5;
   localparam logic [3:0] S_RD2   = 4'd6;
   localparam logic [3:0] S_EVAL  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;
   localparam logic [3:0] S_LOAD  = 4'd9;

   cfg_type cfg_ff;
   logic [3:0]  state_ff, state_in;
   logic [16:0] pos_ff, pos_in;
   logic [16:0] snap_ff, snap_in;
   logic        match_ff, match_in, status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [16:0] out_pos_ff, out_snap_ff;
   logic        out_match_ff, out_status_ff;
   // divider: remainder of magnitude / step
   logic [16:0] rem_ff, rem_in, mag_ff, mag_in;
   logic [4:0]  bit_ff, bit_in;
   logic        neg_ff, neg_in;
   // zero-crossing search
   logic [16:0] dist_ff, dist_in;
   logic        side_ff, side_in; // 0 before, 1 after
   logic [16:0] cand_ff, cand_in;
   logic [SAMPLE_BITS-1:0] la_ff, la_in, ra_ff, ra_in;
   logic [16:0] ld_pos_ff;
   logic [SAMPLE_BITS-1:0] ld_l_ff, ld_r_ff;

   logic [ABITS-1:0] rd_addr;
   logic [SAMPLE_BITS-1:0] l_rd, r_rd;
   logic wr_en;
   logic res_take;

   assign wr_en = (state_ff == S_LOAD) && (ld_pos_ff < 17'(MAX_FRAMES));

   sbs_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAMES)) u_left (
      .clock(clock), .wr_en(wr_en), .wr_addr(ld_pos_ff[ABITS-1:0]), .wr_data(ld_l_ff),
      .rd_addr(rd_addr), .rd_data(l_rd));
   sbs_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAMES)) u_right (
      .clock(clock), .wr_en(wr_en), .wr_addr(ld_pos_ff[ABITS-1:0]), .wr_data(ld_r_ff),
      .rd_addr(rd_addr), .rd_data(r_rd));

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SNAP_KIND: cfg_ff.snap_kind      <= csr_data[0];
            CSR_DIRECTION: cfg_ff.direction      <= csr_data[1:0];
            CSR_CHANNEL:   cfg_ff.channel_select <= csr_data[1:0];
            CSR_STEREO:    cfg_ff.stereo         <= csr_data[0];
            CSR_RADIUS:    cfg_ff.search_radius  <= csr_data[10:0];
            CSR_STEP:      cfg_ff.grid_step      <= csr_data;
            CSR_ORIGIN:    cfg_ff.grid_origin    <= csr_data;
            CSR_FRAMES:    cfg_ff.frame_count    <= csr_data;
            default: ;
         endcase
      end
   end

   logic bad_cfg;
   assign bad_cfg = (cfg_ff.direction > DIR_AFTER) || (cfg_ff.channel_select > CH_RIGHT)
      || (cfg_ff.channel_select == CH_RIGHT && !cfg_ff.stereo)
      || (cfg_ff.search_radius > 11'(MAX_RADIUS)) || (cfg_ff.grid_step == '0)
      || (18'(cfg_ff.frame_count) > 18'(MAX_FRAMES))
      || (cfg_ff.grid_origin > cfg_ff.frame_count) || (pos_ff > cfg_ff.frame_count);

   function automatic logic breaks(input logic [SAMPLE_BITS-1:0] a,
                                   input logic [SAMPLE_BITS-1:0] b);
      breaks = !((a != '0) && (b != '0) && (a[SAMPLE_BITS-1] == b[SAMPLE_BITS-1]));
   endfunction

   // divider step and grid selection
   logic [17:0] rem_sh;
   logic [17:0] lo_s, hi_s, step18;
   logic [17:0] dlo, dhi;
   logic have_lo, have_hi;
   logic cross_ok;

   assign req_ready = (state_ff == S_IDLE);
   assign res_take = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   // frame-1 is addressed in S_RD1 and the frame itself from S_RD2 on
   assign rd_addr = (state_ff == S_RD1) ? ABITS'(cand_ff - 17'd1) : ABITS'(cand_ff);

   always_comb begin
      state_in = state_ff; pos_in = pos_ff; snap_in = snap_ff;
      match_in = match_ff; status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rem_in = rem_ff; mag_in = mag_ff; bit_in = bit_ff; neg_in = neg_ff;
      dist_in = dist_ff; side_in = side_ff; cand_in = cand_ff;
      la_in = la_ff; ra_in = ra_ff;
      rem_sh = {rem_ff, mag_ff[16]};
      step18 = {1'b0, cfg_ff.grid_step};
      lo_s = '0; hi_s = '0; dlo = '0; dhi = '0; have_lo = 1'b0; have_hi = 1'b0;
      cross_ok = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               pos_in = req_position;
               state_in = req_mode ? S_CHECK : S_LOAD;
            end
         end
         S_LOAD: state_in = S_IDLE;
         S_CHECK: begin
            snap_in = pos_ff; match_in = 1'b0; status_in = 1'b0;
            if (bad_cfg) begin
               status_in = 1'b1; state_in = S_DONE;
            end else if (cfg_ff.snap_kind) begin
               neg_in = pos_ff < cfg_ff.grid_origin;
               mag_in = neg_in ? cfg_ff.grid_origin - pos_ff : pos_ff - cfg_ff.grid_origin;
               rem_in = '0; bit_in = 5'd17; state_in = S_DIV;
            end else begin
               dist_in = '0; side_in = 1'b0; state_in = S_CAND;
            end
         end
         S_DIV: begin
            if (rem_sh >= step18) begin
               rem_in = 17'(rem_sh - step18);
            end else begin
               rem_in = rem_sh[16:0];
            end
            mag_in = {mag_ff[15:0], 1'b0};
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd1) state_in = S_GRID;
         end
         S_GRID: begin
            // below the origin the floor lies (step - remainder) under the point unless on the grid
            if (neg_ff && rem_ff != '0) begin
               lo_s = 18'(pos_ff) - (step18 - 18'(rem_ff));
               have_lo = (18'(pos_ff) >= step18 - 18'(rem_ff))
                  && (cfg_ff.direction != DIR_AFTER);
            end else begin
               lo_s = 18'(pos_ff) - 18'(rem_ff);
               have_lo = cfg_ff.direction != DIR_AFTER;
            end
            hi_s = (lo_s == 18'(pos_ff)) ? lo_s : lo_s + step18;
            have_hi = (hi_s <= 18'(cfg_ff.frame_count)) && cfg_ff.direction != DIR_BEFORE;
            dlo = 18'(pos_ff) - lo_s;
            dhi = hi_s - 18'(pos_ff);
            if (have_lo || have_hi) begin
               match_in = 1'b1;
               snap_in = (have_lo && (!have_hi || dlo <= dhi)) ? lo_s[16:0] : hi_s[16:0];
            end
            state_in = S_DONE;
         end
         S_CAND: begin
            if (dist_ff > 17'(cfg_ff.search_radius)) begin
               state_in = S_DONE;
            end else if (side_ff == 1'b0
                         && (cfg_ff.direction == DIR_AFTER || dist_ff > pos_ff)) begin
               side_in = 1'b1;
            end else if (side_ff == 1'b1 && (cfg_ff.direction == DIR_BEFORE
                         || dist_ff > cfg_ff.frame_count - pos_ff)) begin
               side_in = 1'b0; dist_in = dist_ff + 17'd1;
            end else begin
               cand_in = side_ff ? pos_ff + dist_ff : pos_ff - dist_ff;
               state_in = S_RD1;
            end
         end
         S_RD1: state_in = S_RD2;
         S_RD2: begin
            la_in = l_rd; ra_in = r_rd; state_in = S_EVAL;
         end
         S_EVAL: begin
            if (cand_ff == '0 || cand_ff == cfg_ff.frame_count
                || 18'(cand_ff) >= 18'(MAX_FRAMES)) begin
               cross_ok = 1'b1;
            end else if (!cfg_ff.stereo || cfg_ff.channel_select == CH_LEFT) begin
               cross_ok = breaks(la_ff, l_rd);
            end else begin
               cross_ok = breaks(ra_ff, r_rd)
                  && (cfg_ff.channel_select != CH_BOTH || breaks(la_ff, l_rd));
            end
            if (cross_ok) begin
               match_in = 1'b1; snap_in = cand_ff; state_in = S_DONE;
            end else if (side_ff == 1'b0) begin
               side_in = 1'b1; state_in = S_CAND;
            end else begin
               side_in = 1'b0; dist_in = dist_ff + 17'd1; state_in = S_CAND;
            end
         end
         S_DONE: begin
            if (res_take) begin
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in; snap_ff <= snap_in; match_ff <= match_in; status_ff <= status_in;
      rem_ff <= rem_in; mag_ff <= mag_in; bit_ff <= bit_in; neg_ff <= neg_in;
      dist_ff <= dist_in; side_ff <= side_in; cand_ff <= cand_in;
      la_ff <= la_in;
      ra_ff <= ra_in;
      if (req_valid && req_ready) begin
         ld_pos_ff <= req_position; ld_l_ff <= req_left_sample; ld_r_ff <= req_right_sample;
      end
      if (res_take) begin
         out_pos_ff <= pos_ff; out_snap_ff <= snap_ff;
         out_match_ff <= match_ff; out_status_ff <= status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_original_position = out_pos_ff;
   assign rsp_snapped_position = out_snap_ff;
   assign rsp_matched = out_match_ff;
   assign rsp_status = out_status_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid) else $error("result lost");
   a_err_nomatch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status)
         |-> (!rsp_matched && rsp_snapped_position == rsp_original_position))
      else $error("error result inconsistent");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready)
         |=> (rsp_valid && $stable(rsp_snapped_position)
              && $stable(rsp_original_position)))
      else $error("waiting result changed");
endmodule
